@@ design/tcpp_pkg.sv @@
package tcpp_pkg;

    // Input word: one pixel's co-located samples
    typedef struct packed {
        logic [7:0]  filter_value;
        logic [15:0] height_sample;
        logic [7:0]  slope_sample;
        logic [7:0]  relative_elevation;
    } t_px_in;

    // Output word: result color and verdict
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [1:0] verdict;
    } t_px_out;

    // Verdict codes
    localparam logic [1:0] VERDICT_GRAY  = 2'd0;
    localparam logic [1:0] VERDICT_LOW   = 2'd1;
    localparam logic [1:0] VERDICT_HIGH  = 2'd2;
    localparam logic [1:0] VERDICT_STEEP = 2'd3;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_LIM  = 2'd2;
    localparam int CFG_DATA_W = 12;

    // Gray level arithmetic
    localparam int SUM_W     = 11;  // 2f+3d, signed
    localparam int PROD_W    = 19;  // (2f+3d)*m, signed
    localparam int NUM_W     = 19;  // offset numerator, unsigned
    localparam int DEN_W     = 9;   // 2m
    localparam int QUO_W     = 10;  // offset quotient
    localparam int DIV_STEPS = QUO_W;
    localparam int GRAY_OFS  = 192; // keeps the numerator non-negative

    // Pipeline: two front stages, the divider, one output stage
    localparam int NSTG = DIV_STEPS + 3;

endpackage

@@ design/terrain_cover_probability_pixel.sv @@
// Vegetation probability pixel: one pixel in, one color pixel out.
//
// Input channel: i_valid / o_stall with word i_word (filter, height, slope,
// relative elevation). A word is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with word o_word (RGB and
// verdict), taken at an edge with o_valid high and i_stall low.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
// selects min height, max height or slope limit; index 3 is ignored.
// Write config only while the pipeline is empty.
//
// Throughput: one word per cycle while the receiver does not stall. Path: the
// two front stages, the 10-stage restoring divider (one quotient bit per stage,
// for the division by twice the slope limit) and the output register. Each
// stage loads whenever it is empty or its successor moves, so a stall from the
// receiver backs up stage by stage and empty slots are filled; nothing is
// dropped or repeated.
// Reset (i_rst_n low, synchronous): pipeline emptied, registers return to
// min 0, max 255, slope limit 255.
module terrain_cover_probability_pixel
    import tcpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_px_in                i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_px_out               o_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        logic [1:0]       verdict;
        logic             white;
    } t_dv;

    localparam int DIFF_W = NUM_W + 1;
    localparam int S2     = 1;          // index of the numerator stage
    localparam int DV0    = 2;          // first divider stage
    localparam int OUT    = NSTG - 1;   // output stage

    // config registers
    logic signed [11:0] r_min_h;
    logic signed [11:0] r_max_h;
    logic [7:0]         r_slope_lim;

    // stage valid bits and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    // stage 1: verdict and product
    logic signed [PROD_W-1:0] r1_prod;
    logic [7:0]               r1_s;
    logic [7:0]               r1_m;
    logic [1:0]               r1_verdict;
    logic                     r1_white;

    // stage 2: offset numerator and divisor
    logic [NUM_W-1:0] r2_num;
    logic [DEN_W-1:0] r2_den;
    logic [1:0]       r2_verdict;
    logic             r2_white;

    // divider stages
    t_dv r_dv [DIV_STEPS];
    t_dv n_dv [DIV_STEPS];
    t_dv w_src [DIV_STEPS];
    logic [DIFF_W-1:0] w_diff [DIV_STEPS];

    t_px_out r_out;
    t_px_out n_out;

    // stage 1 combinational
    logic [7:0]               w_m_eff;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [PROD_W-1:0] n1_prod;
    logic [23:0]              w_hs;
    logic signed [28:0]       w_hs_s;
    logic signed [28:0]       w_min_s;
    logic signed [28:0]       w_max_s;
    logic [1:0]               n1_verdict;

    // stage 2 combinational
    logic signed [NUM_W+1:0]  w_num;

    // output stage combinational
    logic [QUO_W-1:0] w_quo;
    logic [7:0]       w_gray;

    assign o_cfg_ready = 1'b1;

    // Ready chain: a stage loads when empty or when the next one moves.
    always_comb begin
        w_rdy[OUT] = !r_vld[OUT] || !i_stall;
        for (int k = OUT - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[OUT];
    assign o_word  = r_out;

    // Stage 1: height tests, slope test, (2f+3d)*m.
    // A zero limit uses m = 1: the slope is then zero on the gray path,
    // which gives floor((2f+3d)/2).
    always_comb begin
        w_m_eff = (r_slope_lim == 8'd0) ? 8'd1 : r_slope_lim;
        w_sum   = SUM_W'(signed'({1'b0, i_word.filter_value, 1'b0}))
                + SUM_W'(signed'({1'b0, i_word.relative_elevation}) - 10'sd128) * 11'sd3;
        n1_prod = PROD_W'(w_sum) * PROD_W'(signed'({1'b0, w_m_eff}));
        w_hs    = {i_word.height_sample, 8'd0} - {8'd0, i_word.height_sample};
        w_hs_s  = signed'({5'd0, w_hs});
        w_min_s = 29'(signed'({r_min_h, 16'd0}));
        w_max_s = 29'(signed'({r_max_h, 16'd0}));
        n1_verdict = VERDICT_GRAY;
        if (w_hs_s <= w_min_s) begin
            n1_verdict = VERDICT_LOW;
        end
        if (w_hs_s >= w_max_s) begin
            n1_verdict = VERDICT_HIGH;
        end
        if (i_word.slope_sample > r_slope_lim) begin
            n1_verdict = VERDICT_STEEP;
        end
    end

    // Stage 2: numerator + 200s + GRAY_OFS*2m, never negative
    always_comb begin
        w_num = (NUM_W+2)'(r1_prod)
              + (NUM_W+2)'(signed'({1'b0, r1_s})) * (NUM_W+2)'(200)
              + (NUM_W+2)'(signed'({1'b0, r1_m})) * (NUM_W+2)'(2 * GRAY_OFS);
    end

    // Divider: one restoring step per stage, MSB of the quotient first
    always_comb begin
        w_src[0].rem     = r2_num;
        w_src[0].quo     = '0;
        w_src[0].den     = r2_den;
        w_src[0].verdict = r2_verdict;
        w_src[0].white   = r2_white;
        for (int j = 1; j < DIV_STEPS; j++) begin
            w_src[j] = r_dv[j-1];
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            w_diff[j] = {1'b0, w_src[j].rem}
                      - (DIFF_W'(w_src[j].den) << (DIV_STEPS - 1 - j));
            n_dv[j] = w_src[j];
            if (!w_diff[j][DIFF_W-1]) begin
                n_dv[j].rem = w_diff[j][NUM_W-1:0];
                n_dv[j].quo[DIV_STEPS-1-j] = 1'b1;
            end
        end
    end

    // Output: remove offset, clamp, pick color
    always_comb begin
        w_quo = r_dv[DIV_STEPS-1].quo;
        if (w_quo < QUO_W'(GRAY_OFS)) begin
            w_gray = 8'd0;
        end else if (w_quo > QUO_W'(GRAY_OFS + 255)) begin
            w_gray = 8'd255;
        end else begin
            w_gray = 8'(w_quo - QUO_W'(GRAY_OFS));
        end
        n_out.verdict = r_dv[DIV_STEPS-1].verdict;
        case (r_dv[DIV_STEPS-1].verdict)
            VERDICT_LOW: begin
                n_out.red_out = 8'd0; n_out.green_out = 8'd0; n_out.blue_out = 8'd255;
            end
            VERDICT_HIGH: begin
                n_out.red_out = 8'd0; n_out.green_out = 8'd255; n_out.blue_out = 8'd0;
            end
            VERDICT_STEEP: begin
                n_out.red_out = 8'd0; n_out.green_out = 8'd128; n_out.blue_out = 8'd255;
            end
            default: begin
                n_out.red_out = w_gray; n_out.green_out = w_gray; n_out.blue_out = w_gray;
            end
        endcase
        if (r_dv[DIV_STEPS-1].white) begin
            n_out.red_out   = 8'd255;
            n_out.green_out = 8'd255;
            n_out.blue_out  = 8'd255;
            n_out.verdict   = VERDICT_GRAY;
        end
    end

    // Control: valid bits and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_min_h     <= 12'sd0;
            r_max_h     <= 12'sd255;
            r_slope_lim <= 8'd255;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_HEIGHT: r_min_h     <= signed'(i_cfg_data);
                    CFG_MAX_HEIGHT: r_max_h     <= signed'(i_cfg_data);
                    CFG_SLOPE_LIM:  r_slope_lim <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers, loaded when the stage takes a word
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r1_prod    <= n1_prod;
            r1_s       <= i_word.slope_sample;
            r1_m       <= w_m_eff;
            r1_verdict <= n1_verdict;
            r1_white   <= (i_word.filter_value == 8'd255);
        end
        if (w_rdy[S2] && r_vld[S2-1]) begin
            r2_num     <= w_num[NUM_W-1:0];
            r2_den     <= {r1_m, 1'b0};
            r2_verdict <= r1_verdict;
            r2_white   <= r1_white;
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (w_rdy[DV0+j] && r_vld[DV0+j-1]) begin
                r_dv[j] <= n_dv[j];
            end
        end
        if (w_rdy[OUT] && r_vld[OUT-1]) begin
            r_out <= n_out;
        end
    end

endmodule

@@ tb/sv/cover_pixel_checker.sv @@
`timescale 1ns / 1ps

// Watches the pixel, result and register channels. Keeps its own copy of the
// height band and slope limit, predicts each accepted pixel word and checks
// result words in order.
module cover_pixel_checker
    import tcpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_px_valid,
    input  logic                  i_px_stall,
    input  t_px_in                i_px_word,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  t_px_out               i_res_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    logic signed [11:0] band_floor   = 12'sd0;
    logic signed [11:0] band_ceiling = 12'sd255;
    logic [7:0]         steep_limit  = 8'd255;
    t_px_out            expected_colors[$];
    t_px_out            oldest;
    int                 mismatches   = 0;

    // integer division rounding toward minus infinity
    function automatic longint floor_quotient(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic t_px_out predict_cover_pixel(t_px_in px);
        longint  f, h, s, d, m, scaled, level;
        logic [1:0] verdict;
        t_px_out res;
        f = px.filter_value;
        h = px.height_sample;
        s = px.slope_sample;
        d = longint'(px.relative_elevation) - 128;
        m = steep_limit;
        res = '{8'd255, 8'd255, 8'd255, VERDICT_GRAY};
        if (f != 255) begin
            scaled  = h * 255;
            verdict = VERDICT_GRAY;
            if (scaled <= longint'(band_floor) * 65536)
                verdict = VERDICT_LOW;
            if (scaled >= longint'(band_ceiling) * 65536)
                verdict = VERDICT_HIGH;
            if (s > m)
                verdict = VERDICT_STEEP;
            case (verdict)
                VERDICT_LOW:   res = '{8'd0, 8'd0,   8'd255, VERDICT_LOW};
                VERDICT_HIGH:  res = '{8'd0, 8'd255, 8'd0,   VERDICT_HIGH};
                VERDICT_STEEP: res = '{8'd0, 8'd128, 8'd255, VERDICT_STEEP};
                default: begin
                    // zero limit: slope term dropped
                    if (m == 0)
                        level = floor_quotient(2 * f + 3 * d, 2);
                    else
                        level = floor_quotient((2 * f + 3 * d) * m + 200 * s, 2 * m);
                    if (level < 0)
                        level = 0;
                    if (level > 255)
                        level = 255;
                    res = '{8'(level), 8'(level), 8'(level), VERDICT_GRAY};
                end
            endcase
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            band_floor   = 12'sd0;
            band_ceiling = 12'sd255;
            steep_limit  = 8'd255;
            expected_colors.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_HEIGHT: band_floor   = i_cfg_data;
                    CFG_MAX_HEIGHT: band_ceiling = i_cfg_data;
                    CFG_SLOPE_LIM:  steep_limit  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // result first: a word taken at this edge cannot leave at it
            if (i_res_valid && !i_res_stall) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, i_res_word);
                    mismatches++;
                end else begin
                    oldest = expected_colors.pop_front();
                    check_field("red_out",   oldest.red_out,   i_res_word.red_out);
                    check_field("green_out", oldest.green_out, i_res_word.green_out);
                    check_field("blue_out",  oldest.blue_out,  i_res_word.blue_out);
                    check_field("verdict",   8'(oldest.verdict), 8'(i_res_word.verdict));
                end
            end
            if (i_px_valid && !i_px_stall)
                expected_colors = {expected_colors, predict_cover_pixel(i_px_word)};
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_colors.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// Top: drives pixel words and register writes into the block, throttles the
// result side, and reports the verdict from the checker's mismatch count.
module testbench;
    import tcpp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // not a register
    localparam int SEGMENTS     = 7;
    localparam int SEG_WORDS    = 240;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int SETTLE       = NSTG + 4;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  px_valid  = 1'b0;
    logic                  px_stall;
    t_px_in                px_word   = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    t_px_out               res_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_HEIGHT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;

    // idle odds per cycle, in percent, set per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_off_req = 1'b0;

    // band and slope limit as last written; used only to shape stimulus
    int cur_min   = 0;
    int cur_max   = 255;
    int cur_slope = 255;

    terrain_cover_probability_pixel DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (px_valid),
        .o_stall     (px_stall),
        .i_word      (px_word),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_word      (res_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cover_pixel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_px_valid   (px_valid),
        .i_px_stall   (px_stall),
        .i_px_word    (px_word),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_res_word   (res_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard stop; a clean run needs a small fraction of this.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side. A hold-off request parks stall high for a long stretch
    // so the pipeline fills and pushes back on the pixel side.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Offer one pixel word after a random idle gap; returns at the edge
    // that took it. Valid stays up across back-to-back words.
    task automatic offer_pixel(input t_px_in px);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            px_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        px_valid <= 1'b1;
        px_word  <= px;
        do @(posedge clk); while (px_stall);
    endtask

    // Wait until every expected result is back, then let the pipe settle.
    task automatic drain_pipeline();
        px_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Caller lowers cfg_valid once the whole group is written.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_limits(input int lo, input int hi, input int slope,
                              input bit poke_unused);
        write_register(CFG_MIN_HEIGHT, 12'(lo));
        write_register(CFG_MAX_HEIGHT, 12'(hi));
        write_register(CFG_SLOPE_LIM,  12'(slope));
        // the spare index must leave all three limits alone
        if (poke_unused)
            write_register(CFG_UNUSED, 12'hFFF);
        cfg_valid <= 1'b0;
        cur_min   = lo;
        cur_max   = hi;
        cur_slope = slope;
    endtask

    // Some white pixels, mostly pixels that pass the band and slope tests so the
    // gray path gets real coverage, then pixels sitting on a limit and raw noise.
    function automatic t_px_in next_random_pixel();
        t_px_in px;
        int kind, lo, hi, level, h, edge_lim, s;
        kind = $urandom_range(0, 99);
        px   = {$urandom, 8'($urandom)};
        if (kind < 5) begin
            px.filter_value = 8'd255;
        end else if (kind < 80) begin
            px.filter_value = 8'($urandom_range(0, 254));
            px.slope_sample = 8'($urandom_range(0, cur_slope));
            if (kind < 65) begin
                lo = (cur_min + 1 > 0) ? cur_min + 1 : 0;
                hi = (cur_max - 1 < 255) ? cur_max - 1 : 255;
                if (lo <= hi) begin
                    level = $urandom_range(lo, hi);
                    h = (level * 65536 + int'($urandom_range(0, 65535))) / 255;
                    px.height_sample = (h > 65535) ? 16'hFFFF : 16'(h);
                end
            end else begin
                edge_lim = $urandom_range(0, 1) ? cur_min : cur_max;
                if (edge_lim < 0)
                    edge_lim = 0;
                if (edge_lim > 256)
                    edge_lim = 256;
                h = edge_lim * 65536 / 255 + int'($urandom_range(0, 2)) - 1;
                if (h < 0)
                    h = 0;
                if (h > 65535)
                    h = 65535;
                px.height_sample = 16'(h);
                s = cur_slope + int'($urandom_range(0, 1));
                px.slope_sample = (s > 255) ? 8'd255 : 8'(s);
            end
        end
        return px;
    endfunction

    initial begin
        int lo, hi, slope;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 21;
        rx_idle_pct = 72;

        // Reset limits: min 0, max 255, slope 255. Words are
        // {filter, height, slope, relative elevation}.
        offer_pixel({8'd255, 16'd0,     8'd0,   8'd0});    // no vegetation -> white
        offer_pixel({8'd0,   16'd0,     8'd0,   8'd128});  // height exactly at min
        offer_pixel({8'd0,   16'd65535, 8'd255, 8'd0});    // top height, slope == limit
        offer_pixel({8'd254, 16'd30000, 8'd255, 8'd255});  // gray clamps high
        offer_pixel({8'd100, 16'd30000, 8'd0,   8'd128});  // level ground
        offer_pixel({8'd17,  16'd12345, 8'd77,  8'd131});
        offer_pixel({8'd254, 16'd40000, 8'd128, 8'd127});

        // Widest band, zero slope limit
        drain_pipeline();
        set_limits(-2048, 2047, 0, 1'b0);
        offer_pixel({8'd0,   16'd0,     8'd0,   8'd0});    // gray clamps low
        offer_pixel({8'd1,   16'd0,     8'd0,   8'd129});  // odd sum floors
        offer_pixel({8'd0,   16'd65535, 8'd0,   8'd127});
        offer_pixel({8'd254, 16'd65535, 8'd0,   8'd255});
        offer_pixel({8'd200, 16'd1000,  8'd1,   8'd128});  // any slope is too steep
        offer_pixel({8'd200, 16'd1000,  8'd255, 8'd128});
        offer_pixel({8'd255, 16'd1000,  8'd255, 8'd0});

        // Inverted band; also a write to the spare index
        drain_pipeline();
        set_limits(100, 50, 128, 1'b1);
        offer_pixel({8'd10,  16'd0,     8'd0,   8'd128});  // below min only
        offer_pixel({8'd10,  16'd65535, 8'd0,   8'd128});  // above max only
        offer_pixel({8'd10,  16'd25000, 8'd0,   8'd128});  // fails both, max wins
        offer_pixel({8'd10,  16'd0,     8'd129, 8'd128});  // steep beats low
        offer_pixel({8'd10,  16'd65535, 8'd200, 8'd128});  // steep beats high
        offer_pixel({8'd255, 16'd0,     8'd255, 8'd0});

        // Random segments: receiver slow / sender slow / no idling.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_pipeline();
            if (seg < 2) begin
                tx_idle_pct = 21;
                rx_idle_pct = 72;
            end else if (seg < 4) begin
                tx_idle_pct = 72;
                rx_idle_pct = 21;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            lo    = $urandom_range(0, 80);
            lo    = lo - 20;
            hi    = $urandom_range(120, 270);
            slope = $urandom_range(1, 255);
            if (seg == 3) begin
                // fully inverted extremes: every pixel fails a height test
                lo    = 2047;
                hi    = -2048;
                slope = 255;
            end else if (seg == 5) begin
                lo    = -1;
                hi    = 256;
                slope = 0;
            end
            set_limits(lo, hi, slope, 1'b0);
            if (seg == SEGMENTS - 1)
                hold_off_req = 1'b1;
            repeat (SEG_WORDS) offer_pixel(next_random_pixel());
        end

        drain_pipeline();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
